/* rtl/core/edf_task_table_defines.svh */
// Assertion macros used by the edf_task_table back end.
`ifndef EDF_TASK_TABLE_DEFINES_SVH
`define EDF_TASK_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define EDFT_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);
`define EDFT_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define EDFT_ASSERT(name, cond, msg)
`define EDFT_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

/* rtl/core/edft_pkg.sv */
// Types and codes shared by the EDF task table front and back ends.
package edft_pkg;

	localparam int OP_W   = 3;
	localparam int PID_W  = 22;
	localparam int PER_W  = 20;
	localparam int CMP_W  = 16;
	localparam int TICK_W = 32;
	localparam int ST_W   = 2;
	localparam int TCNT_W = 5;
	localparam int KIND_W = 3;

	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_READY  = 3'd2;
	localparam logic [OP_W-1:0] OP_SLEEP  = 3'd3;
	localparam logic [OP_W-1:0] OP_SELECT = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_NONE = 2'd2;
	localparam logic [ST_W-1:0] ST_DUP  = 2'd3;

	// Request classes decided by the front end.
	localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIND   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SELECT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NOP    = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OP_W-1:0]   op;
		logic [PID_W-1:0]  pid;
		logic [TICK_W-1:0] deadline;
		logic [PER_W-1:0]  period;
		logic [CMP_W-1:0]  compute;
	} cmd_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [TICK_W-1:0] deadline;
		logic [PER_W-1:0]  period;
		logic [CMP_W-1:0]  compute;
	} slot_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [PID_W-1:0]  chosen_id;
		logic [TICK_W-1:0] chosen_deadline;
		logic [TCNT_W-1:0] task_count;
	} res_t;

endpackage

/* rtl/core/edft_front.sv */
// Front end of the EDF task table: request intake, decode and a two-entry queue.
module edft_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [edft_pkg::OP_W-1:0]    operation,
	input  logic [edft_pkg::PID_W-1:0]   task_id,
	input  logic [edft_pkg::PER_W-1:0]   period_ticks,
	input  logic [edft_pkg::CMP_W-1:0]   compute_time,
	input  logic [edft_pkg::TICK_W-1:0]  now_ticks,
	output logic                         cmd_valid,
	output edft_pkg::cmd_t               cmd,
	input  logic                         cmd_take
);

	edft_pkg::cmd_t ent_q [2];
	edft_pkg::cmd_t cmd_in;
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           accepted;

	always_comb begin
		cmd_in.op       = operation;
		cmd_in.pid      = task_id;
		// The deadline wraps modulo the tick counter width.
		cmd_in.deadline = now_ticks + {{(edft_pkg::TICK_W-edft_pkg::PER_W){1'b0}}, period_ticks};
		cmd_in.period   = period_ticks;
		cmd_in.compute  = compute_time;
		unique case (operation)
			edft_pkg::OP_ADD:    cmd_in.kind = edft_pkg::KIND_ADD;
			edft_pkg::OP_REMOVE,
			edft_pkg::OP_READY,
			edft_pkg::OP_SLEEP:  cmd_in.kind = edft_pkg::KIND_FIND;
			edft_pkg::OP_SELECT: cmd_in.kind = edft_pkg::KIND_SELECT;
			edft_pkg::OP_CLEAR:  cmd_in.kind = edft_pkg::KIND_CLEAR;
			default:             cmd_in.kind = edft_pkg::KIND_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign accepted  = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (accepted) begin
			ent_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accepted) begin
				wp_q <= ~wp_q;
			end
			if (cmd_take) begin
				rp_q <= ~rp_q;
			end
			unique case ({accepted, cmd_take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/core/edft_back.sv */
// Back end of the EDF task table: slot storage, scan sequencer and result queue.
`include "edf_task_table_defines.svh"

module edft_back #(
	parameter int MAX_TASKS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  edft_pkg::cmd_t               cmd,
	output logic                         cmd_take,
	output logic                         empty,
	input  logic                         pop,
	output edft_pkg::res_t               res
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]             state_q;
	edft_pkg::cmd_t         cur_q;
	logic [IW-1:0]          idx_q;
	logic                   eval_v_s1;
	logic [IW-1:0]          eval_idx_s1;

	edft_pkg::slot_t        mem [MAX_TASKS];
	edft_pkg::slot_t        rd_q;
	edft_pkg::slot_t        wr_slot;
	logic                   mem_we;

	logic [MAX_TASKS-1:0]   valid_q;
	logic [MAX_TASKS-1:0]   ready_q;
	logic [MAX_TASKS-1:0]   valid_d;
	logic [MAX_TASKS-1:0]   ready_d;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          cnt_d;
	logic [31:0]            cnt_wide;

	logic                   found_q;
	logic [IW-1:0]          found_idx_q;
	logic                   free_v_q;
	logic [IW-1:0]          free_idx_q;
	logic                   best_v_q;
	logic [edft_pkg::TICK_W-1:0] best_dl_q;
	logic [edft_pkg::PID_W-1:0]  best_pid_q;

	logic                   e_valid;
	logic                   e_ready;
	logic                   e_match;
	logic                   e_free;
	logic                   e_better;

	edft_pkg::res_t         res_d;
	edft_pkg::res_t         res_q [2];
	logic                   res_wp_q;
	logic                   res_rp_q;
	logic [1:0]             res_cnt_q;
	logic                   res_push;
	logic                   res_pop;

	assign cmd_take = (state_q == S_IDLE) && cmd_valid && (res_cnt_q != 2'd2);

	// Sequencer: one memory read per slot, each evaluated in the cycle after its read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			eval_v_s1 <= 1'b0;
		end else begin
			eval_v_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						idx_q <= '0;
						if (cmd.kind == edft_pkg::KIND_CLEAR || cmd.kind == edft_pkg::KIND_NOP)
							state_q <= S_DONE;
						else
							state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == LAST_IDX)
						state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_DONE;
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_q <= cmd;
		end
		eval_idx_s1 <= idx_q;
	end

	always_comb begin
		wr_slot.pid      = cur_q.pid;
		wr_slot.deadline = cur_q.deadline;
		wr_slot.period   = cur_q.period;
		wr_slot.compute  = cur_q.compute;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[free_idx_q] <= wr_slot;
		end
		rd_q <= mem[idx_q];
	end

	assign e_valid  = valid_q[eval_idx_s1];
	assign e_ready  = ready_q[eval_idx_s1];
	assign e_match  = e_valid && (rd_q.pid == cur_q.pid);
	assign e_free   = !e_valid;
	assign e_better = e_valid && e_ready && (!best_v_q || (best_dl_q > rd_q.deadline));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			free_v_q <= 1'b0;
			best_v_q <= 1'b0;
		end else if (cmd_take) begin
			found_q  <= 1'b0;
			free_v_q <= 1'b0;
			best_v_q <= 1'b0;
		end else if (eval_v_s1) begin
			if (e_match)
				found_q <= 1'b1;
			if (e_free)
				free_v_q <= 1'b1;
			if (e_better)
				best_v_q <= 1'b1;
		end
	end

	// Only the first hit is kept, so ties in the deadline go to the lowest slot.
	always_ff @(posedge clk) begin
		if (eval_v_s1) begin
			if (e_match && !found_q)
				found_idx_q <= eval_idx_s1;
			if (e_free && !free_v_q)
				free_idx_q <= eval_idx_s1;
			if (e_better) begin
				best_dl_q  <= rd_q.deadline;
				best_pid_q <= rd_q.pid;
			end
		end
	end

	always_comb begin
		valid_d = valid_q;
		ready_d = ready_q;
		cnt_d   = cnt_q;
		mem_we  = 1'b0;
		res_d.status          = edft_pkg::ST_OK;
		res_d.chosen_id       = '0;
		res_d.chosen_deadline = '0;
		if (state_q == S_DONE) begin
			unique case (cur_q.kind)
				edft_pkg::KIND_ADD: begin
					if (found_q) begin
						res_d.status = edft_pkg::ST_DUP;
					end else if (!free_v_q) begin
						res_d.status = edft_pkg::ST_FULL;
					end else begin
						mem_we              = 1'b1;
						valid_d[free_idx_q] = 1'b1;
						ready_d[free_idx_q] = 1'b0;
						cnt_d               = cnt_q + CW'(1);
					end
				end
				edft_pkg::KIND_FIND: begin
					if (!found_q) begin
						res_d.status = edft_pkg::ST_NONE;
					end else if (cur_q.op == edft_pkg::OP_REMOVE) begin
						valid_d[found_idx_q] = 1'b0;
						ready_d[found_idx_q] = 1'b0;
						cnt_d                = cnt_q - CW'(1);
					end else begin
						ready_d[found_idx_q] = (cur_q.op == edft_pkg::OP_READY);
					end
				end
				edft_pkg::KIND_SELECT: begin
					if (!best_v_q) begin
						res_d.status = edft_pkg::ST_NONE;
					end else begin
						res_d.chosen_id       = best_pid_q;
						res_d.chosen_deadline = best_dl_q;
					end
				end
				edft_pkg::KIND_CLEAR: begin
					valid_d = '0;
					ready_d = '0;
					cnt_d   = '0;
				end
				default: begin
				end
			endcase
		end
		cnt_wide         = 32'(cnt_d);
		res_d.task_count = cnt_wide[edft_pkg::TCNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ready_q <= '0;
			cnt_q   <= '0;
		end else begin
			valid_q <= valid_d;
			ready_q <= ready_d;
			cnt_q   <= cnt_d;
		end
	end

	// Result queue of two entries decouples the sequencer from the consumer.
	assign res_push = (state_q == S_DONE);
	assign res_pop  = pop && (res_cnt_q != 2'd0);
	assign empty    = (res_cnt_q == 2'd0);
	assign res      = res_q[res_rp_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wp_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wp_q  <= 1'b0;
			res_rp_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push)
				res_wp_q <= ~res_wp_q;
			if (res_pop)
				res_rp_q <= ~res_rp_q;
			unique case ({res_push, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	`EDFT_ASSERT(a_count_matches_valid, cnt_q == CW'($countones(valid_q)), "task count out of step with valid slots")
	`EDFT_ASSERT(a_ready_needs_valid, (ready_q & ~valid_q) == '0, "ready bit set on a free slot")
	`EDFT_ASSERT(a_done_has_space, (state_q != S_DONE) || (res_cnt_q != 2'd2), "result produced with the queue full")
	`EDFT_ASSERT_NEXT(a_done_leaves_result, (state_q == S_DONE) && !pop, res_cnt_q != 2'd0, "finished request left no result")

endmodule

/* rtl/core/edf_task_table.sv */
// Top level of the EDF task table: front end, back end and their link.
//
// Requests enter through a queue-style port: an item is taken on a rising
// edge where push is high and full is low. Each request carries an operation
// (add, remove, mark ready, mark sleeping, select earliest, clear), a pid, a
// period, a computation time and the current tick count.
// Exactly one result comes back per request, in order, through a second
// queue-style port: it is shown while empty is low and taken on an edge where
// pop is high and empty is low.
// A request that scans the table walks the slot memory through its one read
// port, one slot per cycle, then passes the drain and done states of the back
// end. Clear and undefined codes skip the scan and go straight to done.
// Reset empties the table, both queues and the held count at once; no
// clearing pass is needed, since the contents of free slots are never used.
// When the receiver stalls, two results wait in the result queue, then the
// back end halts, two more requests wait in the front queue and full rises.
module edf_task_table #(
	parameter int MAX_TASKS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [edft_pkg::OP_W-1:0]    operation,
	input  logic [edft_pkg::PID_W-1:0]   task_id,
	input  logic [edft_pkg::PER_W-1:0]   period_ticks,
	input  logic [edft_pkg::CMP_W-1:0]   compute_time,
	input  logic [edft_pkg::TICK_W-1:0]  now_ticks,
	output logic                         empty,
	input  logic                         pop,
	output logic [edft_pkg::ST_W-1:0]    status,
	output logic [edft_pkg::PID_W-1:0]   chosen_id,
	output logic [edft_pkg::TICK_W-1:0]  chosen_deadline,
	output logic [edft_pkg::TCNT_W-1:0]  task_count
);

	logic           cmd_valid;
	logic           cmd_take;
	edft_pkg::cmd_t cmd;
	edft_pkg::res_t res;

	edft_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.task_id      (task_id),
		.period_ticks (period_ticks),
		.compute_time (compute_time),
		.now_ticks    (now_ticks),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	edft_back #(
		.MAX_TASKS (MAX_TASKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign status          = res.status;
	assign chosen_id       = res.chosen_id;
	assign chosen_deadline = res.chosen_deadline;
	assign task_count      = res.task_count;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the EDF task table: random and directed requests against a predictor.
`timescale 1ns / 1ps

module tb_top;
	import edft_pkg::*;

	localparam int MAX_TASKS = 16;
	localparam int SCAN_CYCLES = MAX_TASKS + 3;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_REQS = 950;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [PID_W-1:0]  pid;
		logic [PER_W-1:0]  period;
		logic [CMP_W-1:0]  compute;
		logic [TICK_W-1:0] now_val;
		int unsigned       gap;
		bit                drain;
	} sched_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [OP_W-1:0] operation = '0;
	logic [PID_W-1:0] task_id = '0;
	logic [PER_W-1:0] period_ticks = '0;
	logic [CMP_W-1:0] compute_time = '0;
	logic [TICK_W-1:0] now_ticks = '0;
	logic full;
	logic empty;
	logic [ST_W-1:0] status;
	logic [PID_W-1:0] chosen_id;
	logic [TICK_W-1:0] chosen_deadline;
	logic [TCNT_W-1:0] task_count;

	// Predictor copy of the task table.
	logic tbl_valid [MAX_TASKS];
	logic tbl_ready [MAX_TASKS];
	logic [PID_W-1:0] tbl_pid [MAX_TASKS];
	logic [TICK_W-1:0] tbl_deadline [MAX_TASKS];
	logic [TCNT_W-1:0] tbl_count;

	sched_req_t pending_reqs[$];
	res_t expected_results[$];
	sched_req_t cur_req;
	logic [PID_W-1:0] pid_pool[$];
	int gap_left = 0;
	int stall_left = 0;
	int stall_mode = 1;
	int results_seen = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;
	int gap_mode = 1;
	int reqs_made = 0;
	logic [TICK_W-1:0] shared_now;
	logic [PER_W-1:0] shared_period;

	edf_task_table #(
		.MAX_TASKS(MAX_TASKS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.task_id(task_id),
		.period_ticks(period_ticks),
		.compute_time(compute_time),
		.now_ticks(now_ticks),
		.empty(empty),
		.pop(pop),
		.status(status),
		.chosen_id(chosen_id),
		.chosen_deadline(chosen_deadline),
		.task_count(task_count)
	);

	always #5 clk = ~clk;

	function automatic int find_task(input logic [PID_W-1:0] pid);
		for (int i = 0; i < MAX_TASKS; i++)
			if (tbl_valid[i] && tbl_pid[i] == pid)
				return i;
		return -1;
	endfunction

	// Applies one request to the predictor table and returns the result it should give.
	function automatic res_t edf_predict(input sched_req_t r);
		res_t out;
		int hit;
		out = '0;
		hit = -1;
		case (r.op)
			OP_ADD: begin
				if (find_task(r.pid) >= 0) begin
					out.status = ST_DUP;
				end else begin
					for (int i = MAX_TASKS - 1; i >= 0; i--)
						if (!tbl_valid[i])
							hit = i;
					if (hit < 0) begin
						out.status = ST_FULL;
					end else begin
						tbl_valid[hit] = 1'b1;
						tbl_ready[hit] = 1'b0;
						tbl_pid[hit] = r.pid;
						tbl_deadline[hit] = r.now_val + TICK_W'(r.period);
						tbl_count = tbl_count + 1'b1;
					end
				end
			end
			OP_REMOVE, OP_READY, OP_SLEEP: begin
				hit = find_task(r.pid);
				if (hit < 0) begin
					out.status = ST_NONE;
				end else if (r.op == OP_REMOVE) begin
					tbl_valid[hit] = 1'b0;
					tbl_ready[hit] = 1'b0;
					if (tbl_count != 0)
						tbl_count = tbl_count - 1'b1;
				end else begin
					tbl_ready[hit] = (r.op == OP_READY);
				end
			end
			OP_SELECT: begin
				// Strict compare keeps the lowest slot on equal deadlines.
				for (int i = 0; i < MAX_TASKS; i++)
					if (tbl_valid[i] && tbl_ready[i] &&
					    (hit < 0 || tbl_deadline[hit] > tbl_deadline[i]))
						hit = i;
				if (hit < 0) begin
					out.status = ST_NONE;
				end else begin
					out.chosen_id = tbl_pid[hit];
					out.chosen_deadline = tbl_deadline[hit];
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < MAX_TASKS; i++) begin
					tbl_valid[i] = 1'b0;
					tbl_ready[i] = 1'b0;
				end
				tbl_count = '0;
			end
			default: begin
			end
		endcase
		out.task_count = tbl_count;
		return out;
	endfunction

	task automatic queue_req(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
	                         input logic [PER_W-1:0] period, input logic [CMP_W-1:0] compute,
	                         input logic [TICK_W-1:0] now_val, input bit drain);
		sched_req_t r;
		r.op = op;
		r.pid = pid;
		r.period = period;
		r.compute = compute;
		r.now_val = now_val;
		r.drain = drain;
		case (gap_mode)
			0: r.gap = 0;
			1: r.gap = $urandom_range(0, 10);
			default: r.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
		endcase
		pending_reqs.push_back(r);
		reqs_made++;
	endtask

	function automatic logic [PID_W-1:0] fresh_pid();
		return PID_W'($urandom_range(0, (1 << PID_W) - 1));
	endfunction

	function automatic logic [PID_W-1:0] pick_pid();
		if (pid_pool.size() == 0 || $urandom_range(0, 19) == 0)
			return fresh_pid();
		return pid_pool[$urandom_range(0, pid_pool.size() - 1)];
	endfunction

	function automatic void remember_pid(input logic [PID_W-1:0] pid);
		pid_pool.push_back(pid);
		if (pid_pool.size() > 24)
			void'(pid_pool.pop_front());
	endfunction

	function automatic logic [PER_W-1:0] rand_period();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return PER_W'($urandom_range(0, 255));
			default: return PER_W'($urandom_range(0, (1 << PER_W) - 1));
		endcase
	endfunction

	function automatic logic [TICK_W-1:0] rand_now();
		if ($urandom_range(0, 9) == 0)
			return 32'hFFFF_FFFF - $urandom_range(0, 2000);
		return $urandom();
	endfunction

	// Adds a task, sometimes reusing the last shared release point to force deadline ties.
	task automatic queue_add(input logic [PID_W-1:0] pid, input bit drain);
		if ($urandom_range(0, 3) == 0) begin
			queue_req(OP_ADD, pid, shared_period, CMP_W'($urandom()), shared_now, drain);
		end else begin
			shared_now = rand_now();
			shared_period = rand_period();
			queue_req(OP_ADD, pid, shared_period, CMP_W'($urandom()), shared_now, drain);
		end
	endtask

	// Sender: presents queued requests, honoring per-request gaps and drain points.
	always @(posedge clk) begin
		bit take_next;
		if (arst_n) begin
			take_next = !push || !full;
			if (push && !full) begin
				expected_results.push_back(edf_predict(cur_req));
				gap_left = cur_req.gap;
			end
			if (take_next) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_reqs.size() != 0 &&
				             !(pending_reqs[0].drain && expected_results.size() != 0)) begin
					cur_req = pending_reqs.pop_front();
					operation <= cur_req.op;
					task_id <= cur_req.pid;
					period_ticks <= cur_req.period;
					compute_time <= cur_req.compute;
					now_ticks <= cur_req.now_val;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: takes results with random stalls and checks them in order.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: status %0d id %0h deadline %0h count %0d",
					         $time, status, chosen_id, chosen_deadline, task_count);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d, actual %0d",
						         $time, want.status, status);
						mismatch_count++;
					end
					if (chosen_id !== want.chosen_id) begin
						$display("%0t: chosen_id expected %0h, actual %0h",
						         $time, want.chosen_id, chosen_id);
						mismatch_count++;
					end
					if (chosen_deadline !== want.chosen_deadline) begin
						$display("%0t: chosen_deadline expected %0h, actual %0h",
						         $time, want.chosen_deadline, chosen_deadline);
						mismatch_count++;
					end
					if (task_count !== want.task_count) begin
						$display("%0t: task_count expected %0d, actual %0d",
						         $time, want.task_count, task_count);
						mismatch_count++;
					end
				end
				results_seen++;
				if (results_seen % 50 == 0)
					stall_mode = $urandom_range(0, 2);
				case (stall_mode)
					0: stall_left = 0;
					1: stall_left = $urandom_range(0, 10);
					default: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
				endcase
			end
			if (!pop || !empty) begin
				if (stall_left > 0) begin
					stall_left--;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int kind;
		int n;
		int r;
		bit drain;
		logic [PID_W-1:0] pid;
		for (int i = 0; i < MAX_TASKS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_ready[i] = 1'b0;
			tbl_pid[i] = '0;
			tbl_deadline[i] = '0;
		end
		tbl_count = '0;
		shared_now = '0;
		shared_period = '0;

		// Directed requests: empty table, field extremes, duplicates, ties, odd codes, clear.
		gap_mode = 1;
		queue_req(OP_SELECT, '0, '0, '0, '0, 0);
		queue_req(OP_REMOVE, '0, '0, '0, '0, 0);
		queue_req(OP_ADD, '0, '0, '0, '0, 0);
		queue_req(OP_ADD, '0, 20'd5, 16'd1, 32'd7, 0);
		queue_req(OP_ADD, '1, '1, '1, '1, 0);
		queue_req(OP_SELECT, '0, '0, '0, '0, 0);
		queue_req(OP_READY, '0, '0, '0, '0, 0);
		queue_req(OP_READY, '1, '0, '0, '0, 0);
		queue_req(OP_SELECT, '1, '1, '1, '1, 0);
		queue_req(OP_SLEEP, '0, '0, '0, '0, 0);
		queue_req(OP_SELECT, '0, '0, '0, '0, 0);
		queue_req(OP_ADD, 22'h155555, 20'h0AAAA, 16'h5A5A, 32'h8000_0000, 0);
		queue_req(OP_ADD, 22'h2AAAAA, 20'h0AAAA, 16'hA5A5, 32'h8000_0000, 0);
		queue_req(OP_READY, 22'h155555, '0, '0, '0, 0);
		queue_req(OP_READY, 22'h2AAAAA, '0, '0, '0, 0);
		queue_req(OP_SLEEP, '1, '0, '0, '0, 0);
		queue_req(OP_SELECT, '0, '0, '0, '0, 0);
		queue_req(OP_REMOVE, 22'h155555, '0, '0, '0, 0);
		queue_req(OP_SELECT, '0, '0, '0, '0, 0);
		queue_req(3'd6, 22'h123456, 20'h54321, 16'h1234, 32'hDEAD_BEEF, 0);
		queue_req(3'd7, '1, '1, '1, '1, 0);
		queue_req(OP_SLEEP, 22'h123456, '0, '0, '0, 0);
		queue_req(OP_CLEAR, '0, '0, '0, '0, 0);
		queue_req(OP_SELECT, '0, '0, '0, '0, 0);

		// Random episodes; the first one, after a full drain, queues more adds than the table has slots.
		kind = 0;
		drain = 1'b1;
		while (reqs_made < RANDOM_REQS) begin
			gap_mode = $urandom_range(0, 2);
			if (kind < 2) begin
				n = $urandom_range(MAX_TASKS + 1, MAX_TASKS + 4);
				for (int i = 0; i < n; i++) begin
					pid = ($urandom_range(0, 7) == 0) ? pick_pid() : fresh_pid();
					remember_pid(pid);
					queue_add(pid, drain);
					drain = 1'b0;
					if ($urandom_range(0, 2) == 0)
						queue_req(OP_READY, pid, rand_period(), CMP_W'($urandom()), rand_now(), 0);
				end
				queue_req(OP_SELECT, pick_pid(), rand_period(), CMP_W'($urandom()), rand_now(), 0);
			end else if (kind == 9) begin
				// Noise: any code with arbitrary fields.
				n = $urandom_range(5, 12);
				for (int i = 0; i < n; i++) begin
					queue_req(OP_W'($urandom_range(0, 7)), fresh_pid(), rand_period(),
					          CMP_W'($urandom()), $urandom(), drain);
					drain = 1'b0;
				end
			end else begin
				n = $urandom_range(20, 40);
				for (int i = 0; i < n; i++) begin
					r = $urandom_range(0, 99);
					pid = pick_pid();
					if (r < 25) begin
						if ($urandom_range(0, 3) == 0) begin
							pid = fresh_pid();
							remember_pid(pid);
						end
						queue_add(pid, drain);
					end else if (r < 37) begin
						queue_req(OP_REMOVE, pid, rand_period(), CMP_W'($urandom()), rand_now(), drain);
					end else if (r < 57) begin
						queue_req(OP_READY, pid, rand_period(), CMP_W'($urandom()), rand_now(), drain);
					end else if (r < 67) begin
						queue_req(OP_SLEEP, pid, rand_period(), CMP_W'($urandom()), rand_now(), drain);
					end else if (r < 94) begin
						queue_req(OP_SELECT, pid, rand_period(), CMP_W'($urandom()), rand_now(), drain);
					end else if (r < 96) begin
						queue_req(OP_CLEAR, pid, rand_period(), CMP_W'($urandom()), rand_now(), drain);
					end else begin
						queue_req(OP_W'($urandom_range(6, 7)), pid, rand_period(),
						          CMP_W'($urandom()), rand_now(), drain);
					end
					drain = 1'b0;
				end
			end
			kind = $urandom_range(0, 9);
			drain = ($urandom_range(0, 4) == 0);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || push || expected_results.size() != 0);
		repeat (2 * SCAN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
